// ===== design/cpu_alu_with_flags_assert.svh =====
// Assertion macros for the ALU top-level design file.
`ifndef CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPUALU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpualu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPUALU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpualu: next-cycle check failed");

`endif

// ===== design/cpualu_pkg.sv =====
package cpualu_pkg;

    // Operation codes
    localparam logic [4:0] MODE_ADD  = 5'd0;
    localparam logic [4:0] MODE_ADC  = 5'd1;
    localparam logic [4:0] MODE_SUB  = 5'd2;
    localparam logic [4:0] MODE_SBC  = 5'd3;
    localparam logic [4:0] MODE_AND  = 5'd4;
    localparam logic [4:0] MODE_XOR  = 5'd5;
    localparam logic [4:0] MODE_OR   = 5'd6;
    localparam logic [4:0] MODE_CP   = 5'd7;
    localparam logic [4:0] MODE_INC  = 5'd8;
    localparam logic [4:0] MODE_DEC  = 5'd9;
    localparam logic [4:0] MODE_RLC  = 5'd10;
    localparam logic [4:0] MODE_RRC  = 5'd11;
    localparam logic [4:0] MODE_RL   = 5'd12;
    localparam logic [4:0] MODE_RR   = 5'd13;
    localparam logic [4:0] MODE_SLA  = 5'd14;
    localparam logic [4:0] MODE_SRA  = 5'd15;
    localparam logic [4:0] MODE_SLL  = 5'd16;
    localparam logic [4:0] MODE_SRL  = 5'd17;
    localparam logic [4:0] MODE_DAA  = 5'd18;
    localparam logic [4:0] MODE_BIT  = 5'd19;
    localparam logic [4:0] MODE_SET  = 5'd20;
    localparam logic [4:0] MODE_RES  = 5'd21;
    localparam logic [4:0] MODE_ADDW = 5'd22;
    localparam logic [4:0] MODE_ADCW = 5'd23;
    localparam logic [4:0] MODE_SBCW = 5'd24;
    localparam logic [4:0] MODE_RLCA = 5'd25;
    localparam logic [4:0] MODE_RRCA = 5'd26;
    localparam logic [4:0] MODE_RLA  = 5'd27;
    localparam logic [4:0] MODE_RRA  = 5'd28;

    // Rotate and shift kinds
    localparam logic [2:0] ROT_RLC = 3'd0;
    localparam logic [2:0] ROT_RRC = 3'd1;
    localparam logic [2:0] ROT_RL  = 3'd2;
    localparam logic [2:0] ROT_RR  = 3'd3;
    localparam logic [2:0] ROT_SLA = 3'd4;
    localparam logic [2:0] ROT_SRA = 3'd5;
    localparam logic [2:0] ROT_SLL = 3'd6;
    localparam logic [2:0] ROT_SRL = 3'd7;

    // Flag bit positions
    localparam int FLAG_S  = 7;
    localparam int FLAG_Z  = 6;
    localparam int FLAG_Y  = 5;
    localparam int FLAG_H  = 4;
    localparam int FLAG_X  = 3;
    localparam int FLAG_PV = 2;
    localparam int FLAG_N  = 1;
    localparam int FLAG_C  = 0;

    localparam logic [7:0] DAA_LIMIT    = 8'h99;
    localparam logic [7:0] DAA_CORR_HI  = 8'h60;
    localparam logic [7:0] DAA_CORR_LO  = 8'h06;
    localparam logic [3:0] DAA_NIB_MAX  = 4'd9;
    localparam logic [7:0] INC_OVF_FROM = 8'h7F;
    localparam logic [7:0] DEC_OVF_FROM = 8'h80;

    typedef struct packed {
        logic [4:0]  mode;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [15:0] word_left;
        logic [15:0] word_right;
        logic [2:0]  bit_pos;
        logic [7:0]  flags_in;
    } cpualu_req_t;

    typedef struct packed {
        logic [7:0]  byte_result;
        logic [15:0] word_result;
        logic [7:0]  flags_out;
        logic        writes_back;
    } cpualu_rsp_t;

    // Even parity of a byte: one when the count of ones is even
    function automatic logic parity_even(input logic [7:0] v);
        return ~(^v);
    endfunction

    // Rotate or shift a byte; returns {carry out, result}
    function automatic logic [8:0] rot_shift(input logic [2:0] kind,
                                             input logic [7:0] v,
                                             input logic cin);
        logic [8:0] r;
        case (kind)
            ROT_RLC: r = {v[7], v[6:0], v[7]};
            ROT_RRC: r = {v[0], v[0], v[7:1]};
            ROT_RL:  r = {v[7], v[6:0], cin};
            ROT_RR:  r = {v[0], cin, v[7:1]};
            ROT_SLA: r = {v[7], v[6:0], 1'b0};
            ROT_SRA: r = {v[0], v[7], v[7:1]};
            ROT_SLL: r = {v[7], v[6:0], 1'b1};
            ROT_SRL: r = {v[0], 1'b0, v[7:1]};
            default: r = {v[0], 1'b0, v[7:1]};
        endcase
        return r;
    endfunction

endpackage

// ===== design/cpualu_in_stage.sv =====
module cpualu_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  cpualu_pkg::cpualu_req_t req_data,
    output logic                  op_valid,
    input  logic                  op_stall,
    output cpualu_pkg::cpualu_req_t op_data
);

    logic                    valid_reg;
    logic                    valid_next;
    cpualu_pkg::cpualu_req_t data_reg;
    logic                    load;

    // Advance when empty or when the next stage takes the held word
    assign load       = !valid_reg || !op_stall;
    assign req_stall  = !load;
    assign valid_next = load ? req_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && req_valid)
        begin
            data_reg <= req_data;
        end
    end

    assign op_valid = valid_reg;
    assign op_data  = data_reg;

endmodule

// ===== design/cpualu_exec.sv =====
module cpualu_exec (
    input  cpualu_pkg::cpualu_req_t op,
    output cpualu_pkg::cpualu_rsp_t res
);

    always_comb
    begin
        logic [7:0]  a;
        logic [7:0]  v;
        logic [7:0]  f;
        logic        cin;
        logic        c;
        logic        sub;
        logic [8:0]  sum9;
        logic [4:0]  half5;
        logic        ov;
        logic        h;
        logic [7:0]  br;
        logic [15:0] wres;
        logic [7:0]  fo;
        logic        wb;
        logic [8:0]  rot;
        logic [7:0]  corr;
        logic        cy;
        logic        tbit;
        logic [7:0]  mask;
        logic [16:0] sum17;
        logic [12:0] half13;
        logic [7:0]  hi;

        a     = op.acc;
        v     = op.operand;
        f     = op.flags_in;
        cin   = f[cpualu_pkg::FLAG_C];
        c     = 1'b0;
        sub   = 1'b0;
        sum9  = '0;
        half5 = '0;
        ov    = 1'b0;
        h     = 1'b0;
        br    = a;
        wres  = '0;
        fo    = f;
        wb    = 1'b0;
        rot   = '0;
        corr  = '0;
        cy    = 1'b0;
        tbit  = 1'b0;
        mask  = 8'd1 << op.bit_pos;
        sum17 = '0;
        half13 = '0;
        hi    = '0;

        case (op.mode)
            cpualu_pkg::MODE_ADD, cpualu_pkg::MODE_ADC, cpualu_pkg::MODE_SUB,
            cpualu_pkg::MODE_SBC, cpualu_pkg::MODE_CP:
            begin
                sub = (op.mode == cpualu_pkg::MODE_SUB) || (op.mode == cpualu_pkg::MODE_SBC)
                   || (op.mode == cpualu_pkg::MODE_CP);
                c   = ((op.mode == cpualu_pkg::MODE_ADC) || (op.mode == cpualu_pkg::MODE_SBC))
                   && cin;
                if (sub)
                begin
                    sum9  = {1'b0, a} - {1'b0, v} - {8'd0, c};
                    half5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c};
                    ov    = (a[7] ^ v[7]) & (a[7] ^ sum9[7]);
                end
                else
                begin
                    sum9  = {1'b0, a} + {1'b0, v} + {8'd0, c};
                    half5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
                    ov    = ~(a[7] ^ v[7]) & (a[7] ^ sum9[7]);
                end
                br = sum9[7:0];
                fo = {br[7], (br == 8'd0), 1'b0, half5[4], 1'b0, ov, sub, sum9[8]};
                // Compare takes the undocumented bits from the operand
                if (op.mode == cpualu_pkg::MODE_CP)
                begin
                    fo[cpualu_pkg::FLAG_Y] = v[5];
                    fo[cpualu_pkg::FLAG_X] = v[3];
                end
                else
                begin
                    fo[cpualu_pkg::FLAG_Y] = br[5];
                    fo[cpualu_pkg::FLAG_X] = br[3];
                end
                wb = (op.mode != cpualu_pkg::MODE_CP);
            end
            cpualu_pkg::MODE_AND, cpualu_pkg::MODE_XOR, cpualu_pkg::MODE_OR:
            begin
                if (op.mode == cpualu_pkg::MODE_AND)
                begin
                    br = a & v;
                end
                else if (op.mode == cpualu_pkg::MODE_XOR)
                begin
                    br = a ^ v;
                end
                else
                begin
                    br = a | v;
                end
                fo = {br[7], (br == 8'd0), br[5], (op.mode == cpualu_pkg::MODE_AND), br[3],
                      cpualu_pkg::parity_even(br), 2'b00};
                wb = 1'b1;
            end
            cpualu_pkg::MODE_INC, cpualu_pkg::MODE_DEC:
            begin
                if (op.mode == cpualu_pkg::MODE_DEC)
                begin
                    br = v - 8'd1;
                    ov = (v == cpualu_pkg::DEC_OVF_FROM);
                    h  = (br[3:0] == 4'hF);
                end
                else
                begin
                    br = v + 8'd1;
                    ov = (v == cpualu_pkg::INC_OVF_FROM);
                    h  = (br[3:0] == 4'h0);
                end
                fo = {br[7], (br == 8'd0), br[5], h, br[3], ov,
                      (op.mode == cpualu_pkg::MODE_DEC), cin};
                wb = 1'b1;
            end
            cpualu_pkg::MODE_RLC, cpualu_pkg::MODE_RRC, cpualu_pkg::MODE_RL,
            cpualu_pkg::MODE_RR, cpualu_pkg::MODE_SLA, cpualu_pkg::MODE_SRA,
            cpualu_pkg::MODE_SLL, cpualu_pkg::MODE_SRL:
            begin
                rot = cpualu_pkg::rot_shift(3'(op.mode - cpualu_pkg::MODE_RLC), v, cin);
                br  = rot[7:0];
                fo  = {br[7], (br == 8'd0), br[5], 1'b0, br[3],
                       cpualu_pkg::parity_even(br), 1'b0, rot[8]};
                wb  = 1'b1;
            end
            cpualu_pkg::MODE_DAA:
            begin
                if ((a > cpualu_pkg::DAA_LIMIT) || cin)
                begin
                    corr = corr | cpualu_pkg::DAA_CORR_HI;
                    cy   = 1'b1;
                end
                if ((a[3:0] > cpualu_pkg::DAA_NIB_MAX) || f[cpualu_pkg::FLAG_H])
                begin
                    corr = corr | cpualu_pkg::DAA_CORR_LO;
                end
                br = f[cpualu_pkg::FLAG_N] ? (a - corr) : (a + corr);
                fo = {br[7], (br == 8'd0), br[5], (a[4] ^ br[4]), br[3],
                      cpualu_pkg::parity_even(br), f[cpualu_pkg::FLAG_N], cy};
                wb = 1'b1;
            end
            cpualu_pkg::MODE_BIT:
            begin
                tbit = v[op.bit_pos];
                br   = v;
                fo   = {((op.bit_pos == 3'd7) && tbit), !tbit, v[5], 1'b1, v[3],
                        !tbit, 1'b0, cin};
            end
            cpualu_pkg::MODE_SET:
            begin
                br = v | mask;
                wb = 1'b1;
            end
            cpualu_pkg::MODE_RES:
            begin
                br = v & ~mask;
                wb = 1'b1;
            end
            cpualu_pkg::MODE_ADDW, cpualu_pkg::MODE_ADCW, cpualu_pkg::MODE_SBCW:
            begin
                c = (op.mode != cpualu_pkg::MODE_ADDW) && cin;
                if (op.mode == cpualu_pkg::MODE_SBCW)
                begin
                    sum17  = {1'b0, op.word_left} - {1'b0, op.word_right} - {16'd0, c};
                    half13 = {1'b0, op.word_left[11:0]} - {1'b0, op.word_right[11:0]}
                           - {12'd0, c};
                    ov     = (op.word_left[15] ^ op.word_right[15])
                           & (op.word_left[15] ^ sum17[15]);
                end
                else
                begin
                    sum17  = {1'b0, op.word_left} + {1'b0, op.word_right} + {16'd0, c};
                    half13 = {1'b0, op.word_left[11:0]} + {1'b0, op.word_right[11:0]}
                           + {12'd0, c};
                    ov     = ~(op.word_left[15] ^ op.word_right[15])
                           & (op.word_left[15] ^ sum17[15]);
                end
                wres = sum17[15:0];
                hi   = wres[15:8];
                br   = '0;
                if (op.mode == cpualu_pkg::MODE_ADDW)
                begin
                    // Plain word add keeps sign, zero and overflow
                    fo = {f[cpualu_pkg::FLAG_S], f[cpualu_pkg::FLAG_Z], hi[5], half13[12],
                          hi[3], f[cpualu_pkg::FLAG_PV], 1'b0, sum17[16]};
                end
                else
                begin
                    fo = {hi[7], (wres == 16'd0), hi[5], half13[12], hi[3], ov,
                          (op.mode == cpualu_pkg::MODE_SBCW), sum17[16]};
                end
                wb = 1'b1;
            end
            cpualu_pkg::MODE_RLCA, cpualu_pkg::MODE_RRCA, cpualu_pkg::MODE_RLA,
            cpualu_pkg::MODE_RRA:
            begin
                rot = cpualu_pkg::rot_shift(3'(op.mode - cpualu_pkg::MODE_RLCA), a, cin);
                br  = rot[7:0];
                fo  = {f[cpualu_pkg::FLAG_S], f[cpualu_pkg::FLAG_Z], br[5], 1'b0, br[3],
                       f[cpualu_pkg::FLAG_PV], 1'b0, rot[8]};
                wb  = 1'b1;
            end
            default:
            begin
                br   = a;
                wres = '0;
                fo   = f;
                wb   = 1'b0;
            end
        endcase

        res.byte_result = br;
        res.word_result = wres;
        res.flags_out   = fo;
        res.writes_back = wb;
    end

endmodule

// ===== design/cpualu_out_stage.sv =====
module cpualu_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    output logic                  res_stall,
    input  cpualu_pkg::cpualu_rsp_t res_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output cpualu_pkg::cpualu_rsp_t rsp_data
);

    logic                    valid_reg;
    logic                    valid_next;
    cpualu_pkg::cpualu_rsp_t data_reg;
    logic                    load;

    // Take a new result when empty or when the held one leaves this cycle
    assign load       = !valid_reg || !rsp_stall;
    assign res_stall  = !load;
    assign valid_next = load ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            data_reg <= res_data;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = data_reg;

endmodule

// ===== design/cpu_alu_with_flags.sv =====
// Channel   Direction  Handshake             Word
// --------  ---------  --------------------  -----------------------------------
// req       in         req_valid, req_stall  req_data  (cpualu_req_t)
// rsp       out        rsp_valid, rsp_stall  rsp_data  (cpualu_rsp_t)
//
// A word passes the operand register, then the result register.
// One word is accepted per cycle unless req_stall is high; the single-pass ALU between the two registers sets this.
// Reset (rst_n low, asynchronous) empties both registers; the block holds no other state.
// A stalled result is held; the operand register still takes one more word behind it.
// req_stall rises only when both registers are full and rsp_stall is high.
module cpu_alu_with_flags (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  cpualu_pkg::cpualu_req_t req_data,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output cpualu_pkg::cpualu_rsp_t rsp_data
);

`include "cpu_alu_with_flags_assert.svh"

    logic                    op_valid;
    logic                    op_stall;
    cpualu_pkg::cpualu_req_t op_data;
    cpualu_pkg::cpualu_rsp_t res_data;

    // Operand register: hold the accepted word until the result register can take it
    cpualu_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data)
    );

    // ALU proper: all operations in one pass of shallow adders and selects
    cpualu_exec u_exec (
        .op  (op_data),
        .res (res_data)
    );

    // Result register: hold the result while the consumer stalls
    cpualu_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (op_valid),
        .res_stall (op_stall),
        .res_data  (res_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // An accepted word must sit in the operand register on the next cycle
    `CPUALU_ASSERT_NEXT(a_req_lands, req_valid && !req_stall, op_valid)
    // A word moving out of the operand register must appear as a result
    `CPUALU_ASSERT_NEXT(a_op_advances, op_valid && !op_stall, rsp_valid)
    // Stall the requester only when both registers are full and the output is blocked
    `CPUALU_ASSERT_NOW(a_stall_cause, req_stall, op_valid && rsp_valid && rsp_stall)
    // Operations that do not write back never produce a word result
    `CPUALU_ASSERT_NOW(a_nowb_word_zero, rsp_valid && !rsp_data.writes_back,
        rsp_data.word_result == 16'd0)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import cpualu_pkg::*;

    // Cycles the receiver refuses results in one go, to fill both registers.
    localparam int LONG_HOLD = 40;
    // Words per random phase.
    localparam int PHASE_WORDS = 430;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    cpualu_req_t req_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    cpualu_rsp_t rsp_data;

    // Words waiting to be offered, and results owed by the block, oldest first.
    cpualu_req_t pending_words[$];
    cpualu_rsp_t owed_results[$];

    // Idle chances in percent, set per phase by the sequencer.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Long hold-off requests: the sequencer bumps the asked count, the receiver
    // takes each one up in its own process.
    int holds_asked = 0;
    int holds_taken = 0;
    int hold_left = 0;

    int words_sent = 0;
    int results_checked = 0;
    int mismatches = 0;

    cpu_alu_with_flags DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Assemble a flags byte; bits 5 and 3 always follow xy_src.
    function automatic logic [7:0] make_flags(input logic [7:0] xy_src,
                                              input logic s, input logic z,
                                              input logic h, input logic pv,
                                              input logic n, input logic c);
        logic [7:0] fl;
        fl = '0;
        fl[FLAG_S]  = s;
        fl[FLAG_Z]  = z;
        fl[FLAG_Y]  = xy_src[FLAG_Y];
        fl[FLAG_H]  = h;
        fl[FLAG_X]  = xy_src[FLAG_X];
        fl[FLAG_PV] = pv;
        fl[FLAG_N]  = n;
        fl[FLAG_C]  = c;
        return fl;
    endfunction

    // One rotate or shift step; the bit pushed out comes back on cout.
    function automatic logic [7:0] rotate_byte(input logic [2:0] kind, input logic [7:0] v,
                                               input logic cin, output logic cout);
        logic [7:0] rv;
        case (kind)
            ROT_RLC:
            begin
                cout = v[7];
                rv   = {v[6:0], v[7]};
            end
            ROT_RRC:
            begin
                cout = v[0];
                rv   = {v[0], v[7:1]};
            end
            ROT_RL:
            begin
                cout = v[7];
                rv   = {v[6:0], cin};
            end
            ROT_RR:
            begin
                cout = v[0];
                rv   = {cin, v[7:1]};
            end
            ROT_SLA:
            begin
                cout = v[7];
                rv   = v << 1;
            end
            ROT_SRA:
            begin
                cout = v[0];
                rv   = {v[7], v[7:1]};
            end
            ROT_SLL:
            begin
                cout = v[7];
                rv   = {v[6:0], 1'b1};
            end
            default:
            begin
                cout = v[0];
                rv   = v >> 1;
            end
        endcase
        return rv;
    endfunction

    // Work out the result word the ALU owes for one request word.
    function automatic cpualu_rsp_t predict_alu(input cpualu_req_t w);
        cpualu_rsp_t r;
        logic [7:0]  f, res, corr;
        logic [8:0]  sum9;
        logic [4:0]  half5;
        logic [16:0] sum17;
        logic [12:0] half13;
        logic [15:0] wres;
        logic        cin, cy, sub, ov, tested;
        f   = w.flags_in;
        cin = f[FLAG_C];
        // Unused codes fall through with these values.
        r.byte_result = w.acc;
        r.word_result = '0;
        r.flags_out   = f;
        r.writes_back = 1'b0;
        case (w.mode)
            MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBC, MODE_CP:
            begin
                cy  = (w.mode == MODE_ADC || w.mode == MODE_SBC) ? cin : 1'b0;
                sub = (w.mode == MODE_SUB || w.mode == MODE_SBC || w.mode == MODE_CP);
                if (sub)
                begin
                    sum9  = {1'b0, w.acc} - {1'b0, w.operand} - 9'(cy);
                    half5 = {1'b0, w.acc[3:0]} - {1'b0, w.operand[3:0]} - 5'(cy);
                    ov    = (w.acc[7] ^ w.operand[7]) & (w.acc[7] ^ sum9[7]);
                end
                else
                begin
                    sum9  = {1'b0, w.acc} + {1'b0, w.operand} + 9'(cy);
                    half5 = {1'b0, w.acc[3:0]} + {1'b0, w.operand[3:0]} + 5'(cy);
                    ov    = ~(w.acc[7] ^ w.operand[7]) & (w.acc[7] ^ sum9[7]);
                end
                res = sum9[7:0];
                r.byte_result = res;
                // Compare takes bits 5 and 3 from the operand.
                r.flags_out = make_flags((w.mode == MODE_CP) ? w.operand : res, res[7],
                                         res == 8'h00, half5[4], ov, sub, sum9[8]);
                r.writes_back = (w.mode != MODE_CP);
            end
            MODE_AND, MODE_XOR, MODE_OR:
            begin
                if (w.mode == MODE_AND)
                    res = w.acc & w.operand;
                else if (w.mode == MODE_XOR)
                    res = w.acc ^ w.operand;
                else
                    res = w.acc | w.operand;
                r.byte_result = res;
                r.flags_out = make_flags(res, res[7], res == 8'h00, w.mode == MODE_AND,
                                         ~^res, 1'b0, 1'b0);
                r.writes_back = 1'b1;
            end
            MODE_INC, MODE_DEC:
            begin
                // Carry is left alone.
                if (w.mode == MODE_DEC)
                begin
                    res = w.operand - 8'd1;
                    ov  = (w.operand == DEC_OVF_FROM);
                    cy  = (res[3:0] == 4'hF);
                end
                else
                begin
                    res = w.operand + 8'd1;
                    ov  = (w.operand == INC_OVF_FROM);
                    cy  = (res[3:0] == 4'h0);
                end
                r.byte_result = res;
                r.flags_out = make_flags(res, res[7], res == 8'h00, cy, ov,
                                         w.mode == MODE_DEC, cin);
                r.writes_back = 1'b1;
            end
            MODE_RLC, MODE_RRC, MODE_RL, MODE_RR, MODE_SLA, MODE_SRA, MODE_SLL, MODE_SRL:
            begin
                res = rotate_byte(3'(w.mode - MODE_RLC), w.operand, cin, cy);
                r.byte_result = res;
                r.flags_out = make_flags(res, res[7], res == 8'h00, 1'b0, ~^res, 1'b0, cy);
                r.writes_back = 1'b1;
            end
            MODE_DAA:
            begin
                corr = 8'h00;
                cy   = 1'b0;
                if (w.acc > DAA_LIMIT || cin)
                begin
                    corr = corr | DAA_CORR_HI;
                    cy   = 1'b1;
                end
                if (w.acc[3:0] > DAA_NIB_MAX || f[FLAG_H])
                    corr = corr | DAA_CORR_LO;
                res = f[FLAG_N] ? (w.acc - corr) : (w.acc + corr);
                r.byte_result = res;
                r.flags_out = make_flags(res, res[7], res == 8'h00, w.acc[4] ^ res[4],
                                         ~^res, f[FLAG_N], cy);
                r.writes_back = 1'b1;
            end
            MODE_BIT:
            begin
                tested = w.operand[w.bit_pos];
                r.byte_result = w.operand;
                r.flags_out = make_flags(w.operand, (w.bit_pos == 3'd7) && tested, ~tested,
                                         1'b1, ~tested, 1'b0, cin);
            end
            MODE_SET:
            begin
                res = w.operand;
                res[w.bit_pos] = 1'b1;
                r.byte_result = res;
                r.writes_back = 1'b1;
            end
            MODE_RES:
            begin
                res = w.operand;
                res[w.bit_pos] = 1'b0;
                r.byte_result = res;
                r.writes_back = 1'b1;
            end
            MODE_ADDW, MODE_ADCW, MODE_SBCW:
            begin
                cy = (w.mode == MODE_ADDW) ? 1'b0 : cin;
                if (w.mode == MODE_SBCW)
                begin
                    sum17  = {1'b0, w.word_left} - {1'b0, w.word_right} - 17'(cy);
                    half13 = {1'b0, w.word_left[11:0]} - {1'b0, w.word_right[11:0]} - 13'(cy);
                    wres   = sum17[15:0];
                    ov     = (w.word_left[15] ^ w.word_right[15]) & (w.word_left[15] ^ wres[15]);
                end
                else
                begin
                    sum17  = {1'b0, w.word_left} + {1'b0, w.word_right} + 17'(cy);
                    half13 = {1'b0, w.word_left[11:0]} + {1'b0, w.word_right[11:0]} + 13'(cy);
                    wres   = sum17[15:0];
                    ov     = ~(w.word_left[15] ^ w.word_right[15]) &
                             (w.word_left[15] ^ wres[15]);
                end
                r.byte_result = 8'h00;
                r.word_result = wres;
                // Plain word add keeps sign, zero and overflow.
                if (w.mode == MODE_ADDW)
                    r.flags_out = make_flags(wres[15:8], f[FLAG_S], f[FLAG_Z], half13[12],
                                             f[FLAG_PV], 1'b0, sum17[16]);
                else
                    r.flags_out = make_flags(wres[15:8], wres[15], wres == 16'h0000,
                                             half13[12], ov, w.mode == MODE_SBCW, sum17[16]);
                r.writes_back = 1'b1;
            end
            MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA:
            begin
                res = rotate_byte(3'(w.mode - MODE_RLCA), w.acc, cin, cy);
                r.byte_result = res;
                r.flags_out = make_flags(res, f[FLAG_S], f[FLAG_Z], 1'b0, f[FLAG_PV],
                                         1'b0, cy);
                r.writes_back = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Bytes lean towards the corner values now and then.
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[4];
        corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(3) == 0)
            return corners[$urandom_range(3)];
        return 8'($urandom_range(255));
    endfunction

    function automatic cpualu_req_t random_word();
        cpualu_req_t w;
        // Mostly real operations; the unused codes turn up rarely.
        if ($urandom_range(24) == 0)
            w.mode = 5'($urandom_range(31, 29));
        else
            w.mode = 5'($urandom_range(28));
        w.acc        = pick_byte();
        w.operand    = pick_byte();
        w.word_left  = 16'($urandom_range(65535));
        w.word_right = 16'($urandom_range(65535));
        w.bit_pos    = 3'($urandom_range(7));
        w.flags_in   = 8'($urandom_range(255));
        return w;
    endfunction

    task automatic queue_word(input logic [4:0] mode, input logic [7:0] acc,
                              input logic [7:0] operand, input logic [15:0] wl,
                              input logic [15:0] wr, input logic [2:0] bp,
                              input logic [7:0] fl);
        cpualu_req_t w;
        w.mode       = mode;
        w.acc        = acc;
        w.operand    = operand;
        w.word_left  = wl;
        w.word_right = wr;
        w.bit_pos    = bp;
        w.flags_in   = fl;
        pending_words.push_back(w);
    endtask

    // Hold the sequencer until every queued word has gone and every result is in.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || req_valid || owed_results.size() != 0);
    endtask

    // Sender: advance to the next word once the current one is taken, or idle
    // at random. A stalled word is held as it is.
    always @(posedge clk or negedge rst_n)
    begin : sender
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_valid <= 1'b1;
                req_data  <= pending_words.pop_front();
                words_sent++;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, or a long hold-off when the sequencer asks.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (holds_taken != holds_asked)
            begin
                holds_taken = holds_asked;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: log what the block owes for each accepted request word, then
    // check each accepted result word against the oldest one owed. Both are
    // sampled at the same edge, so a result leaving as its word is accepted still lines up.
    always @(posedge clk)
    begin : monitor
        cpualu_rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                owed_results.push_back(predict_alu(req_data));
            if (rsp_valid && !rsp_stall)
            begin
                results_checked++;
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result %h arrived with nothing owed", $realtime,
                                 rsp_data);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (rsp_data.byte_result !== want.byte_result)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] byte_result: expected %h, got %h", $realtime,
                                     want.byte_result, rsp_data.byte_result);
                    end
                    if (rsp_data.word_result !== want.word_result)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] word_result: expected %h, got %h", $realtime,
                                     want.word_result, rsp_data.word_result);
                    end
                    if (rsp_data.flags_out !== want.flags_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] flags_out: expected %b, got %b", $realtime,
                                     want.flags_out, rsp_data.flags_out);
                    end
                    if (rsp_data.writes_back !== want.writes_back)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] writes_back: expected %b, got %b", $realtime,
                                     want.writes_back, rsp_data.writes_back);
                    end
                end
            end
        end
    end

    // Sequencer: runs on the falling edge so that queue and knob updates never
    // race the clocked processes above.
    initial
    begin : sequencer
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed words: every operation at least once, at the corners and special cases.
        send_idle_pct = 33;
        recv_idle_pct = 52;
        queue_word(MODE_ADD,  8'hFF, 8'h01, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_ADC,  8'h7F, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'h01);
        queue_word(MODE_SUB,  8'h80, 8'h01, 16'h0000, 16'h0000, 3'd0, 8'hFF);
        queue_word(MODE_SBC,  8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'h01);
        queue_word(MODE_AND,  8'hFF, 8'hFF, 16'h0000, 16'h0000, 3'd0, 8'hFF);
        queue_word(MODE_XOR,  8'hAA, 8'hAA, 16'h0000, 16'h0000, 3'd0, 8'hFF);
        queue_word(MODE_OR,   8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 8'h00);
        // Compare: bits 5 and 3 follow the operand, not the difference.
        queue_word(MODE_CP,   8'h10, 8'h28, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_INC,  8'h00, 8'h7F, 16'h0000, 16'h0000, 3'd0, 8'h01);
        queue_word(MODE_INC,  8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_DEC,  8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 8'h01);
        queue_word(MODE_RLC,  8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_RRC,  8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_RL,   8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 8'h01);
        queue_word(MODE_RR,   8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 8'h01);
        queue_word(MODE_SLA,  8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_SRA,  8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_SLL,  8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_SRL,  8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 8'h00);
        // Decimal adjust after an add past 99, and after a subtract with half borrow.
        queue_word(MODE_DAA,  8'h9A, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_DAA,  8'h0F, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'h12);
        // Bit test: sign only from a set bit 7; a clear bit raises zero and parity.
        queue_word(MODE_BIT,  8'h00, 8'h80, 16'h0000, 16'h0000, 3'd7, 8'h00);
        queue_word(MODE_BIT,  8'h00, 8'hF7, 16'h0000, 16'h0000, 3'd3, 8'h01);
        queue_word(MODE_SET,  8'h00, 8'h00, 16'h0000, 16'h0000, 3'd7, 8'hA5);
        queue_word(MODE_RES,  8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 8'h5A);
        queue_word(MODE_ADDW, 8'h00, 8'h00, 16'hFFFF, 16'h0001, 3'd0, 8'hC4);
        queue_word(MODE_ADCW, 8'h00, 8'h00, 16'h7FFF, 16'h0000, 3'd0, 8'h01);
        queue_word(MODE_SBCW, 8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'h01);
        queue_word(MODE_RLCA, 8'h80, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'hC4);
        queue_word(MODE_RRCA, 8'h01, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_RLA,  8'hFF, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'h00);
        queue_word(MODE_RRA,  8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 8'h01);
        // An unused code passes the accumulator and flags through.
        queue_word(5'd31,     8'hA5, 8'h5A, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF);
        wait_until_drained();

        // Random phase one: sender idles less than the receiver.
        repeat (PHASE_WORDS) pending_words.push_back(random_word());
        wait_until_drained();

        // Random phase two: the other way round.
        send_idle_pct = 52;
        recv_idle_pct = 33;
        repeat (PHASE_WORDS) pending_words.push_back(random_word());
        wait_until_drained();

        // Random phase three: no idling, opened by a long hold-off so that both
        // registers fill and the block stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holds_asked++;
        repeat (PHASE_WORDS) pending_words.push_back(random_word());
        wait_until_drained();

        // Let any stray result show itself before closing.
        repeat (6) @(negedge clk);

        $display("Covered %0d words: every operation and unused codes, corner values,",
                 words_sent);
        $display("  mixed idling on both sides and a %0d-cycle hold-off; %0d results checked.",
                 LONG_HOLD, results_checked);
        if (mismatches == 0)
            $display("All tests passed");
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

    // Drop the run if it hangs.
    initial
    begin : watchdog
        #2000000;
        $display("Timed out with %0d results still owed", owed_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
